// File: rtl/core/mrb_pkg.sv
`default_nettype none

package mrb_pkg;

  localparam int unsigned MAX_MODES_DEF = 32;
  localparam int unsigned SAMPLE_BITS   = 24;
  localparam int unsigned COEF_BITS     = 32;
  localparam int unsigned COEF_WORD     = 32;
  localparam int unsigned HIST_BITS     = 48;
  localparam int unsigned HSUM_BITS     = HIST_BITS + 4;
  localparam int unsigned IN_SHIFT      = 41 - SAMPLE_BITS;
  localparam int unsigned X_PAD         = HIST_BITS - SAMPLE_BITS - IN_SHIFT;
  localparam int unsigned TAP_BITS      = HIST_BITS - IN_SHIFT;
  localparam int unsigned TAPER_BITS    = 17;
  localparam int unsigned MIN_MODES     = 4;
  localparam int unsigned MUTE_LIMIT    = 33;
  localparam int unsigned NUM_SLOTS     = 5;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO     = 2'd2;

  localparam logic [5:0]  MODE_COUNT_RST = 6'd32;
  localparam logic [15:0] WET_GAIN_RST   = 16'd32768;
  localparam logic        STEREO_RST     = 1'b1;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  localparam logic [COEF_WORD-1:0] COEF_KEEP_MASK =
    ~((32'd1 << (COEF_WORD - COEF_BITS)) - 32'd1);

  localparam logic signed [HSUM_BITS-1:0] HSUM_MAX =
    {{(HSUM_BITS-HIST_BITS+1){1'b0}}, {(HIST_BITS-1){1'b1}}};
  localparam logic signed [HSUM_BITS-1:0] HSUM_MIN = ~HSUM_MAX;

  typedef enum logic [1:0] {
    CMD_PROCESS = 2'd0,
    CMD_COEF    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_ACC,
    OP_FIN_Y,
    OP_FIN_T,
    OP_FIN_H1,
    OP_FIN_H2,
    OP_TAP,
    OP_TAP_ACC,
    OP_GAIN,
    OP_STORE
  } dp_op_e;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [23:0]       sample_left;
    logic signed [23:0]       sample_right;
    logic [4:0]               coef_mode;
    logic [2:0]               coef_slot;
    logic signed [31:0]       coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] out_left;
    logic signed [23:0] out_right;
  } out_item_t;

  typedef struct packed {
    dp_op_e     op;
    logic       src_y;
    logic       coef_rd;
    logic [2:0] slot;
    logic       hist_rd;
    logic       ch;
    logic       start_left;
    logic       start_right;
    logic       capture;
    logic       clear_hist;
    logic       coef_wr;
    logic       out_load;
  } dp_cmd_t;

  function automatic logic signed [HIST_BITS-1:0] sat_hist(
    input logic signed [HSUM_BITS-1:0] v
  );
    if (v > HSUM_MAX) begin
      return HSUM_MAX[HIST_BITS-1:0];
    end else if (v < HSUM_MIN) begin
      return HSUM_MIN[HIST_BITS-1:0];
    end
    return v[HIST_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mrb_ctrl.sv
`default_nettype none

module mrb_ctrl import mrb_pkg::*; #(
  parameter int unsigned MAX_MODES = MAX_MODES_DEF,
  localparam int unsigned MODE_W = $clog2(MAX_MODES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        in_cmd_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire logic [5:0]        mode_count_i,
  input  wire logic              stereo_i,
  input  wire logic              mute_i,
  output dp_cmd_t                dp_cmd_o,
  output logic [MODE_W-1:0]      mode_idx_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MODE  = 3'd1;
  localparam logic [2:0] ST_GAIN  = 3'd2;
  localparam logic [2:0] ST_STORE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [4:0] STEP_LAST = 5'd22;

  logic [2:0]        state_q, state_d;
  logic [4:0]        step_q, step_d;
  logic [MODE_W-1:0] k_q, k_d;
  logic              ch_q, ch_d;
  logic              out_valid_q, out_valid_d;
  logic [6:0]        modes_clamped;
  logic [MODE_W-1:0] last_k;

  always_comb begin
    priority if (mode_count_i < 6'(MIN_MODES)) begin
      modes_clamped = 7'(MIN_MODES);
    end else if (7'(mode_count_i) > 7'(MAX_MODES)) begin
      modes_clamped = 7'(MAX_MODES);
    end else begin
      modes_clamped = 7'(mode_count_i);
    end
  end

  assign last_k      = MODE_W'(modes_clamped - 7'd1);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign mode_idx_o  = k_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    k_d         = k_q;
    ch_d        = ch_q;
    dp_cmd_o    = '0;
    dp_cmd_o.ch = ch_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_cmd_i)
            CMD_PROCESS: begin
              dp_cmd_o.capture = 1'b1;
              if (mute_i) begin
                state_d = ST_DONE;
              end else begin
                dp_cmd_o.start_left = 1'b1;
                ch_d    = 1'b0;
                k_d     = '0;
                step_d  = '0;
                state_d = ST_MODE;
              end
            end
            CMD_COEF:  dp_cmd_o.coef_wr    = 1'b1;
            CMD_CLEAR: dp_cmd_o.clear_hist = 1'b1;
            default: ;
          endcase
        end
      end

      ST_MODE: begin
        step_d = step_q + 5'd1;
        unique case (step_q)
          5'd0: begin
            dp_cmd_o.coef_rd = 1'b1;
            dp_cmd_o.slot    = SLOT_B0;
            dp_cmd_o.hist_rd = 1'b1;
          end
          5'd1, 5'd5, 5'd13: dp_cmd_o.op = OP_MUL_HI;
          5'd9, 5'd17: begin
            dp_cmd_o.op    = OP_MUL_HI;
            dp_cmd_o.src_y = 1'b1;
          end
          5'd2, 5'd6, 5'd14: dp_cmd_o.op = OP_MUL_LO;
          5'd10, 5'd18: begin
            dp_cmd_o.op    = OP_MUL_LO;
            dp_cmd_o.src_y = 1'b1;
          end
          5'd3: begin
            dp_cmd_o.op      = OP_ACC;
            dp_cmd_o.coef_rd = 1'b1;
            dp_cmd_o.slot    = SLOT_B1;
          end
          5'd7: begin
            dp_cmd_o.op      = OP_ACC;
            dp_cmd_o.coef_rd = 1'b1;
            dp_cmd_o.slot    = SLOT_A1;
          end
          5'd11: begin
            dp_cmd_o.op      = OP_ACC;
            dp_cmd_o.coef_rd = 1'b1;
            dp_cmd_o.slot    = SLOT_B2;
          end
          5'd15: begin
            dp_cmd_o.op      = OP_ACC;
            dp_cmd_o.coef_rd = 1'b1;
            dp_cmd_o.slot    = SLOT_A2;
          end
          5'd19:        dp_cmd_o.op = OP_ACC;
          5'd4:         dp_cmd_o.op = OP_FIN_Y;
          5'd8, 5'd16:  dp_cmd_o.op = OP_FIN_T;
          5'd12:        dp_cmd_o.op = OP_FIN_H1;
          5'd20:        dp_cmd_o.op = OP_FIN_H2;
          5'd21:        dp_cmd_o.op = OP_TAP;
          STEP_LAST: begin
            dp_cmd_o.op = OP_TAP_ACC;
            step_d      = '0;
            if (k_q == last_k) begin
              state_d = ST_GAIN;
            end else begin
              k_d = k_q + MODE_W'(1);
            end
          end
          default: begin
            step_d  = '0;
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_GAIN: begin
        dp_cmd_o.op = OP_GAIN;
        state_d     = ST_STORE;
      end

      ST_STORE: begin
        dp_cmd_o.op = OP_STORE;
        if (!ch_q && stereo_i) begin
          dp_cmd_o.start_right = 1'b1;
          ch_d    = 1'b1;
          k_d     = '0;
          step_d  = '0;
          state_d = ST_MODE;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // hold the frame until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          dp_cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (dp_cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      k_q         <= '0;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      k_q         <= k_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mrb_datapath.sv
`default_nettype none

module mrb_datapath import mrb_pkg::*; #(
  parameter int unsigned MAX_MODES = MAX_MODES_DEF,
  localparam int unsigned MODE_W = $clog2(MAX_MODES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  input  wire logic [MODE_W-1:0] mode_idx_i,
  input  wire in_item_t          in_item_i,
  input  wire logic [15:0]       wet_gain_i,
  output out_item_t              out_item_o
);

  localparam int unsigned COEF_DEPTH = MAX_MODES * NUM_SLOTS;
  localparam int unsigned CADDR_W    = $clog2(COEF_DEPTH);
  localparam int unsigned HIST_DEPTH = 2 * MAX_MODES;
  localparam int unsigned HIDX_W     = $clog2(HIST_DEPTH);
  localparam int unsigned SUM_W      = TAP_BITS + $clog2(MAX_MODES);
  localparam int unsigned GP_W       = SUM_W + 17;
  localparam int unsigned SC_W       = GP_W - 15;

  localparam logic signed [SC_W-1:0] OUT_MAX =
    {{(SC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SC_W-1:0] OUT_MIN = ~OUT_MAX;

  logic [COEF_WORD-1:0] coef_mem [COEF_DEPTH];
  logic [HIST_BITS-1:0] hist_first_mem [HIST_DEPTH];
  logic [HIST_BITS-1:0] hist_second_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hvalid_q;

  logic signed [COEF_WORD-1:0]   coef_rd_q;
  logic signed [HIST_BITS-1:0]   hist1_rd_q, hist2_rd_q;
  logic                          hvalid_rd_q;
  logic signed [SAMPLE_BITS-1:0] smp_r_q;
  logic signed [HIST_BITS-1:0]   x_q, y_q;
  logic signed [63:0]            prod_q;
  logic signed [79:0]            acc_q;
  logic signed [HSUM_BITS-1:0]   t_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic signed [GP_W-1:0]        gp_q;
  logic signed [SAMPLE_BITS-1:0] res_l_q, res_r_q;
  out_item_t                     out_q;

  logic [TAPER_BITS-1:0] taper_tbl [MAX_MODES];

  logic [HIDX_W-1:0]           hidx;
  logic [CADDR_W-1:0]          coef_rd_addr, coef_wr_addr;
  logic                        coef_wr_ok;
  logic signed [HIST_BITS-1:0] v_sel, h1, h2;
  logic signed [32:0]          mul_a;
  logic signed [31:0]          mul_b;
  logic signed [64:0]          mul_full;
  logic signed [49:0]          term;
  logic signed [HSUM_BITS-1:0] term_ext, h1_ext, h2_ext;
  logic signed [GP_W-1:0]      gp_full;
  logic signed [SC_W-1:0]      scaled;
  logic signed [SAMPLE_BITS-1:0] res_sat;

  for (genvar g = 0; g < MAX_MODES; g++) begin : g_taper
    localparam int unsigned TapR = (131072 / (g + 1) + 1) >> 1;
    assign taper_tbl[g] = TAPER_BITS'(TapR);
  end

  assign hidx = cmd_i.ch ? HIDX_W'(MAX_MODES) + HIDX_W'(mode_idx_i) : HIDX_W'(mode_idx_i);
  assign coef_rd_addr = CADDR_W'(32'(mode_idx_i) * 32'd5 + 32'(cmd_i.slot));
  assign coef_wr_addr = CADDR_W'(32'(in_item_i.coef_mode) * 32'd5 + 32'(in_item_i.coef_slot));
  assign coef_wr_ok   = (in_item_i.coef_slot <= SLOT_A2) &&
                        (32'(in_item_i.coef_mode) < 32'(MAX_MODES));

  assign v_sel = cmd_i.src_y ? y_q : x_q;
  assign h1    = hvalid_rd_q ? hist1_rd_q : '0;
  assign h2    = hvalid_rd_q ? hist2_rd_q : '0;

  always_comb begin
    unique case (cmd_i.op)
      OP_MUL_HI: begin
        mul_a = {v_sel[HIST_BITS-1], v_sel[HIST_BITS-1:16]};
        mul_b = coef_rd_q;
      end
      OP_MUL_LO: begin
        mul_a = {17'd0, v_sel[15:0]};
        mul_b = coef_rd_q;
      end
      OP_TAP: begin
        mul_a = {{(33-TAP_BITS){y_q[HIST_BITS-1]}}, y_q[HIST_BITS-1:IN_SHIFT]};
        mul_b = {{(32-TAPER_BITS){1'b0}}, taper_tbl[mode_idx_i]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign gp_full  = sum_q * $signed({1'b0, wet_gain_i});

  // floor of the Q30 product
  assign term     = acc_q[79:30];
  assign term_ext = {{(HSUM_BITS-50){term[49]}}, term};
  assign h1_ext   = {{(HSUM_BITS-HIST_BITS){h1[HIST_BITS-1]}}, h1};
  assign h2_ext   = {{(HSUM_BITS-HIST_BITS){h2[HIST_BITS-1]}}, h2};

  assign scaled = gp_q[GP_W-1:15];
  always_comb begin
    priority if (scaled > OUT_MAX) begin
      res_sat = OUT_MAX[SAMPLE_BITS-1:0];
    end else if (scaled < OUT_MIN) begin
      res_sat = OUT_MIN[SAMPLE_BITS-1:0];
    end else begin
      res_sat = scaled[SAMPLE_BITS-1:0];
    end
  end

  // coefficient store
  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr && coef_wr_ok) begin
      coef_mem[coef_wr_addr] <= in_item_i.coef_value & COEF_KEEP_MASK;
    end
    if (cmd_i.coef_rd) begin
      coef_rd_q <= coef_mem[coef_rd_addr];
    end
  end

  // filter histories
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FIN_H1) begin
      hist_first_mem[hidx] <= sat_hist(t_q - term_ext + h2_ext);
    end
    if (cmd_i.op == OP_FIN_H2) begin
      hist_second_mem[hidx] <= sat_hist(t_q - term_ext);
    end
    if (cmd_i.hist_rd) begin
      hist1_rd_q  <= hist_first_mem[hidx];
      hist2_rd_q  <= hist_second_mem[hidx];
      hvalid_rd_q <= hvalid_q[hidx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q <= '0;
    end else if (cmd_i.clear_hist) begin
      hvalid_q <= '0;
    end else if (cmd_i.op == OP_FIN_H2) begin
      hvalid_q[hidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smp_r_q <= in_item_i.sample_right;
      res_l_q <= '0;
      res_r_q <= '0;
    end
    if (cmd_i.start_left) begin
      x_q   <= {{X_PAD{in_item_i.sample_left[SAMPLE_BITS-1]}}, in_item_i.sample_left,
                {IN_SHIFT{1'b0}}};
      sum_q <= '0;
    end else if (cmd_i.start_right) begin
      x_q   <= {{X_PAD{smp_r_q[SAMPLE_BITS-1]}}, smp_r_q, {IN_SHIFT{1'b0}}};
      sum_q <= '0;
    end else if (cmd_i.op == OP_TAP_ACC) begin
      sum_q <= sum_q + prod_q[SUM_W+15:16];
    end
    if (cmd_i.out_load) begin
      out_q.out_left  <= res_l_q;
      out_q.out_right <= res_r_q;
    end

    unique case (cmd_i.op)
      OP_MUL_HI, OP_TAP: prod_q <= mul_full[63:0];
      OP_MUL_LO: begin
        prod_q <= mul_full[63:0];
        acc_q  <= {prod_q, 16'd0};
      end
      OP_ACC:   acc_q <= acc_q + {{16{prod_q[63]}}, prod_q};
      OP_FIN_Y: y_q   <= sat_hist(term_ext + h1_ext);
      OP_FIN_T: t_q   <= term_ext;
      OP_GAIN:  gp_q  <= gp_full;
      OP_STORE: begin
        if (cmd_i.ch) begin
          res_r_q <= res_sat;
        end else begin
          res_l_q <= res_sat;
        end
      end
      default: ;
    endcase
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

// File: rtl/core/modal_resonator_bank_unit.sv
// Frame item: the bank runs both channels for stereo, the left only for mono,
// over M modes, M = mode count clamped to 4..MAX_MODES: one shared
// multiplier, 23 steps per mode plus gain and store per channel; muted: zero result.
// Throughput: the next item is accepted in the cycle after the result is loaded,
// later while an earlier result stalls; other commands stay in idle, no result.
// Reset (async, active low) clears control state and histories; coefs undefined.
`default_nettype none

module modal_resonator_bank_unit import mrb_pkg::*; #(
  parameter int unsigned MAX_MODES = MAX_MODES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned MODE_W = $clog2(MAX_MODES);

  logic [5:0]        mode_count_q;
  logic [15:0]       wet_gain_q;
  logic              stereo_q;
  logic              mute;
  dp_cmd_t           dp_cmd;
  logic [MODE_W-1:0] mode_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q <= MODE_COUNT_RST;
      wet_gain_q   <= WET_GAIN_RST;
      stereo_q     <= STEREO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE_COUNT: mode_count_q <= cfg_wdata_i[5:0];
        CFG_WET_GAIN:   wet_gain_q   <= cfg_wdata_i[15:0];
        CFG_STEREO:     stereo_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign mute = (wet_gain_q < 16'(MUTE_LIMIT));

  mrb_ctrl #(
    .MAX_MODES (MAX_MODES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_cmd_i     (in_item_i.cmd),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mode_count_i (mode_count_q),
    .stereo_i     (stereo_q),
    .mute_i       (mute),
    .dp_cmd_o     (dp_cmd),
    .mode_idx_o   (mode_idx)
  );

  mrb_datapath #(
    .MAX_MODES (MAX_MODES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .mode_idx_i (mode_idx),
    .in_item_i  (in_item_i),
    .wet_gain_i (wet_gain_q),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/mrb_checker.sv
`default_nettype none

module mrb_checker import mrb_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_item_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // a frame keeps the block busy
  a_busy_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.cmd == CMD_PROCESS |=> in_stall_o)
    else $error("frame accepted but block not busy");

  // commands other than a frame give no result
  a_no_result_from_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.cmd != CMD_PROCESS && !out_valid_o
    |=> !out_valid_o)
    else $error("result from a non-frame item");

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

endmodule

bind modal_resonator_bank_unit mrb_checker u_mrb_checker (.*);

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

module testbench;
  import mrb_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  modal_resonator_bank_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  localparam int NMODES = 32;
  localparam int SETTLE = 1600;  // longer than a stereo frame at full mode count

  // resonator bank state as the block should hold it
  logic signed [31:0] coef_mem [NMODES*5];
  longint             hist_a   [2*NMODES];
  longint             hist_b   [2*NMODES];
  logic [5:0]         modes_reg;
  logic [15:0]        gain_reg;
  logic               stereo_reg;

  out_item_t frame_q [$];
  int        errors;
  int        idle_pct;
  int        stall_pct;
  bit        hold_go;
  bit        hold_done;
  int        hold_left;

  typedef struct {
    in_item_t  it;
    bit        fixed;
    out_item_t want;
  } dir_row_t;
  dir_row_t dir_tab [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic longint clip(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // floor(v * c / 2^30)
  function automatic longint mulq(longint v, logic signed [31:0] c);
    logic signed [95:0] pv;
    logic signed [95:0] pc;
    logic signed [95:0] p;
    pv = v;
    pc = c;
    p  = pv * pc;
    p  = p >>> 30;
    return longint'(p[63:0]);
  endfunction

  function automatic logic signed [23:0] bank_channel(int ch, logic signed [23:0] smp, int nm);
    longint x;
    longint y;
    longint acc;
    longint rk;
    int     i;
    x   = longint'(smp) <<< IN_SHIFT;
    acc = 0;
    for (int k = 0; k < nm; k++) begin
      i  = ch * NMODES + k;
      y  = clip(mulq(x, coef_mem[k*5+SLOT_B0]) + hist_a[i], HIST_BITS);
      hist_a[i] = clip(mulq(x, coef_mem[k*5+SLOT_B1]) - mulq(y, coef_mem[k*5+SLOT_A1])
                       + hist_b[i], HIST_BITS);
      hist_b[i] = clip(mulq(x, coef_mem[k*5+SLOT_B2]) - mulq(y, coef_mem[k*5+SLOT_A2]),
                       HIST_BITS);
      rk  = ((131072 / (k + 1)) + 1) >>> 1;
      acc += ((y >>> IN_SHIFT) * rk) >>> 16;
    end
    return 24'(clip((acc * longint'(gain_reg)) >>> 15, SAMPLE_BITS));
  endfunction

  task automatic predict_frame(input in_item_t it, output bit has, output out_item_t r);
    int nm;
    has = 1'b0;
    r   = '0;
    case (cmd_e'(it.cmd))
      CMD_COEF: begin
        if (it.coef_slot <= SLOT_A2) coef_mem[it.coef_mode*5+it.coef_slot] = it.coef_value;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < 2*NMODES; i++) begin
          hist_a[i] = 0;
          hist_b[i] = 0;
        end
      end
      CMD_PROCESS: begin
        has = 1'b1;
        if (gain_reg >= MUTE_LIMIT) begin
          nm = modes_reg;
          if (nm < MIN_MODES) nm = MIN_MODES;
          if (nm > NMODES) nm = NMODES;
          r.out_left = bank_channel(0, it.sample_left, nm);
          if (stereo_reg) r.out_right = bank_channel(1, it.sample_right, nm);
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t mk(cmd_e c, logic [23:0] l, logic [23:0] rr,
                                  logic [4:0] m, logic [2:0] s, logic [31:0] v);
    in_item_t it;
    it.cmd          = c;
    it.sample_left  = l;
    it.sample_right = rr;
    it.coef_mode    = m;
    it.coef_slot    = s;
    it.coef_value   = v;
    return it;
  endfunction

  // mostly a stable resonator, now and then any word at all
  function automatic logic [31:0] pick_coef(logic [2:0] s);
    if ($urandom_range(3) == 0) return $urandom;
    case (s)
      SLOT_B0: return 32'sd4194304 + $urandom_range(0, 1 << 24);
      SLOT_B1: return $urandom_range(0, 1 << 20) - (1 << 19);
      SLOT_B2: return -(32'sd4194304 + $urandom_range(0, 1 << 24));
      SLOT_A1: return -32'sd2040109465 + $urandom_range(0, 1 << 26);
      default: return 32'sd966367641 + $urandom_range(0, 1 << 25);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    int       p;
    logic [2:0] s;
    p = $urandom_range(99);
    s = $urandom_range(7);
    if (p < 60) return mk(CMD_PROCESS, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (p < 90) begin
      if ($urandom_range(9) != 0) s = $urandom_range(SLOT_A2);
      return mk(CMD_COEF, $urandom, $urandom, $urandom, s, pick_coef(s));
    end
    if (p < 95) return mk(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    return mk(CMD_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic send(input in_item_t it, input bit fixed, input out_item_t want);
    bit        ok;
    bit        has;
    out_item_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    ok = 1'b0;
    while (!ok) begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end
    predict_frame(it, has, r);
    if (has) frame_q.push_back(fixed ? want : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MODE_COUNT: modes_reg  = val[5:0];
      CFG_WET_GAIN:   gain_reg   = val;
      CFG_STEREO:     stereo_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic add_row(in_item_t it, bit fixed, logic [23:0] l, logic [23:0] rr);
    dir_row_t row;
    row.it             = it;
    row.fixed          = fixed;
    row.want.out_left  = l;
    row.want.out_right = rr;
    dir_tab.push_back(row);
  endtask

  task automatic run_phase(logic [15:0] mc, logic [15:0] wg, logic [15:0] st,
                           int ip, int sp, int count, bit hold);
    write_reg(CFG_MODE_COUNT, mc);
    write_reg(CFG_WET_GAIN, wg);
    write_reg(CFG_STEREO, st);
    idle_pct  = ip;
    stall_pct = sp;
    if (hold) hold_go = 1'b1;
    for (int n = 0; n < count; n++) send(rand_item(), 1'b0, '0);
    drain();
  endtask

  // receiver: random stall, plus one long hold-off counted here
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(negedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected item left %0d right %0d", $time,
                 out_item.out_left, out_item.out_right);
        errors++;
      end else begin
        want = frame_q.pop_front();
        if (out_item.out_left !== want.out_left) begin
          $display("%0t: out_left expected %0d actual %0d", $time,
                   want.out_left, out_item.out_left);
          errors++;
        end
        if (out_item.out_right !== want.out_right) begin
          $display("%0t: out_right expected %0d actual %0d", $time,
                   want.out_right, out_item.out_right);
          errors++;
        end
      end
    end
  end

  initial begin
    int waited;
    errors     = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_go    = 1'b0;
    hold_done  = 1'b0;
    hold_left  = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    out_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    modes_reg  = MODE_COUNT_RST;
    gain_reg   = WET_GAIN_RST;
    stereo_reg = STEREO_RST;
    for (int i = 0; i < 2*NMODES; i++) begin
      hist_a[i] = 0;
      hist_b[i] = 0;
    end
    for (int i = 0; i < NMODES*5; i++) coef_mem[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every coefficient before any frame reads one
    for (int m = 0; m < NMODES; m++)
      for (int s = 0; s <= SLOT_A2; s++)
        send(mk(CMD_COEF, '0, '0, m, s, pick_coef(s) & 32'h0FFF_FFFF | (s == SLOT_A1 ?
             32'hF000_0000 : 32'h0)), 1'b0, '0);

    // zero in, cleared histories: zero out
    add_row(mk(CMD_CLEAR, '0, '0, '0, '0, '0), 1'b0, '0, '0);
    add_row(mk(CMD_PROCESS, '0, '0, '0, '0, '0), 1'b1, '0, '0);
    add_row(mk(CMD_PROCESS, 24'h7FFFFF, 24'h800000, '0, '0, '0), 1'b0, '0, '0);
    add_row(mk(CMD_PROCESS, 24'h800000, 24'h7FFFFF, '0, '0, '0), 1'b0, '0, '0);
    add_row(mk(CMD_NOP, 24'hFFFFFF, 24'hFFFFFF, 5'h1F, 3'h7, 32'hFFFF_FFFF), 1'b0, '0, '0);
    // slots past a2 are dropped
    add_row(mk(CMD_COEF, '0, '0, 5'd0, 3'd5, 32'h7FFF_FFFF), 1'b0, '0, '0);
    add_row(mk(CMD_COEF, '0, '0, 5'd31, 3'd7, 32'h8000_0000), 1'b0, '0, '0);
    add_row(mk(CMD_PROCESS, 24'h123456, 24'hEDCBA9, '0, '0, '0), 1'b0, '0, '0);
    // extreme b0 drives the history into saturation
    add_row(mk(CMD_COEF, '0, '0, 5'd0, SLOT_B0, 32'h7FFF_FFFF), 1'b0, '0, '0);
    add_row(mk(CMD_PROCESS, 24'h7FFFFF, 24'h7FFFFF, '0, '0, '0), 1'b0, '0, '0);
    add_row(mk(CMD_PROCESS, 24'h7FFFFF, 24'h7FFFFF, '0, '0, '0), 1'b0, '0, '0);
    add_row(mk(CMD_COEF, '0, '0, 5'd0, SLOT_B0, 32'h8000_0000), 1'b0, '0, '0);
    add_row(mk(CMD_PROCESS, 24'h7FFFFF, 24'h800000, '0, '0, '0), 1'b0, '0, '0);
    add_row(mk(CMD_COEF, '0, '0, 5'd31, SLOT_A2, 32'h8000_0000), 1'b0, '0, '0);
    add_row(mk(CMD_COEF, '0, '0, 5'd31, SLOT_A1, 32'h7FFF_FFFF), 1'b0, '0, '0);
    add_row(mk(CMD_PROCESS, 24'h800000, 24'h800000, '0, '0, '0), 1'b0, '0, '0);
    add_row(mk(CMD_CLEAR, '0, '0, '0, '0, '0), 1'b0, '0, '0);
    add_row(mk(CMD_PROCESS, '0, '0, '0, '0, '0), 1'b1, '0, '0);
    add_row(mk(CMD_PROCESS, 24'h000001, 24'hFFFFFF, '0, '0, '0), 1'b0, '0, '0);
    foreach (dir_tab[i]) send(dir_tab[i].it, dir_tab[i].fixed, dir_tab[i].want);
    drain();

    // muted: outputs are zero whatever comes in
    write_reg(CFG_WET_GAIN, 16'd32);
    send(mk(CMD_PROCESS, 24'h7FFFFF, 24'h800000, '0, '0, '0), 1'b1, '0);
    send(mk(CMD_PROCESS, 24'h800000, 24'h7FFFFF, '0, '0, '0), 1'b1, '0);
    drain();
    // unknown register index is ignored
    write_reg(2'd3, 16'hFFFF);

    run_phase(16'd4,    16'd32768, 16'd1, 0,  0,  300, 1'b0);
    run_phase(16'd7,    16'd20000, 16'd0, 72, 0,  300, 1'b0);
    run_phase(16'd5,    16'd32,    16'd1, 0,  72, 100, 1'b0);
    run_phase(16'hFFC6, 16'd65535, 16'hFFFF, 21, 21, 300, 1'b0);
    run_phase(16'd0,    16'd33,    16'hFFFE, 0, 0, 250, 1'b0);
    run_phase(16'd32,   16'd32768, 16'd1, 21, 21, 60,  1'b1);
    run_phase(16'hFFFF, 16'd1,     16'd0, 0,  72, 30,  1'b0);
    run_phase(16'd8,    16'd16384, 16'd1, 72, 72, 300, 1'b0);

    waited = 0;
    while (frame_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && frame_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/mrb_pkg.sv
rtl/core/mrb_ctrl.sv
rtl/core/mrb_datapath.sv
rtl/core/modal_resonator_bank_unit.sv
rtl/core/mrb_checker.sv
test/testbench.sv
